### hdl/ssr_pkg.sv
// Shared constants, types and state encodings of the stationary speed ratio block.
package ssr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = 32;
  localparam int RATE_W      = 10;
  localparam int THR_W       = 32;
  localparam int RATIO_W     = 32;
  localparam int IN_TDATA_W  = 3 * POS_W;
  localparam int OUT_TDATA_W = ((RATIO_W + 1 + 7) / 8) * 8;

  // Scaled per-axis difference: |diff| * rate * 2 stays below 2^43.
  localparam int W_W     = POS_W + RATE_W + 1;
  localparam int WL_W    = (W_W + 1) / 2;
  localparam int WH_W    = W_W - WL_W;
  localparam int MUL_A_W = POS_W;
  localparam int MUL_B_W = WL_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // Sum of three squares, its root and the shared compare-subtract width.
  localparam int ACC_W   = 2 * W_W + 2;
  localparam int ROOT_W  = ACC_W / 2;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CS_W    = REM_W + 2;
  localparam int DEN_W   = THR_W + 1;
  localparam int LIM_W   = ROOT_W + DEN_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = RATIO_W;
  localparam int CNT_W   = $clog2(SQRT_STEPS);

  // Configuration register indexes.
  localparam logic CFG_FRAME_RATE      = 1'b0;
  localparam logic CFG_SPEED_THRESHOLD = 1'b1;

  localparam logic [RATE_W-1:0] FRAME_RATE_RST = RATE_W'(30);
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = THR_W'(6554);

  typedef logic [2:0][POS_W-1:0] pos_vec_t;

  typedef struct packed {
    logic start;
    logic scale2;
  } ssr_job_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic [RATIO_W-1:0] ratio;
  } ssr_res_t;

  typedef enum logic [2:0] {
    T_IDLE, T_PLAN, T_RUN, T_HOLD, T_FINISH
  } top_state_t;

  typedef enum logic [2:0] {
    E_IDLE, E_ABS, E_MULW, E_SQ, E_SQRT, E_CHECK, E_DIV, E_DONE
  } eng_state_t;

  typedef enum logic [1:0] {
    PH_LL, PH_HL, PH_HH
  } sq_phase_t;

  typedef enum logic [1:0] {
    B_CUR, B_PREV, B_PPREV
  } bsel_t;

endpackage

### hdl/stationary_speed_ratio_core.sv
// Top level of the stationary speed ratio block: frame history, sequencing and ports.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------------------
//  in_      | input     | in_tvalid/tready   | tdata: pos_x, pos_y, pos_z; tlast: final
//  out_     | output    | out_tvalid/tready  | tdata: speed_ratio, saturated; tlast: end
//  cfg_     | input     | cfg_we (no wait)   | cfg_addr: register index, cfg_wdata: value
//
// Each result keeps the engine busy through the scaled differences and their squares,
// the square root, one check, the divide unless the result saturates, and one handover.
// The next frame is not accepted until the current one has handed its results (none,
// one or two) to the output register, and a full output register holds a finished word back.
// Reset is synchronous and active low, restores 30 frames per second and a threshold
// of 6554, and starts a new run.
module stationary_speed_ratio_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // Fields from bit 0 up: pos_x, pos_y, pos_z.
  input  logic [ssr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0 up: speed_ratio, saturated, zero padding.
  output logic [ssr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [ssr_pkg::THR_W-1:0]        cfg_wdata
);
  import ssr_pkg::*;

  top_state_t          state_r, state_nxt;

  // Configuration registers.
  logic [RATE_W-1:0]   frame_rate_r;
  logic [THR_W-1:0]    threshold_r;

  // Frame history: the current frame and the two before it.
  pos_vec_t            cur_r;
  pos_vec_t            prev_r;
  pos_vec_t            pprev_r;
  logic                last_r;
  logic [1:0]          frames_r;

  // Current job: which frame is subtracted, the scale, and what follows.
  bsel_t               bsel_r;
  logic                scale2_r;
  logic                run_end_r;
  logic                second_r;
  pos_vec_t            b_pos;

  // Output register.
  logic                out_valid_r;
  logic [RATIO_W-1:0]  out_ratio_r;
  logic                out_sat_r;
  logic                out_last_r;

  ssr_job_t            job;
  ssr_res_t            res;

  logic                in_accept;
  logic                no_result;
  logic                out_free;
  logic                job_start;
  logic                out_load;
  logic                plan_first;
  logic                plan_second;
  logic                ready_c;

  assign in_accept = in_tvalid && in_tready;
  // The first frame of a longer run waits for its neighbor before it reports.
  assign no_result = (frames_r == 2'd0) && !last_r;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    case (bsel_r)
      B_CUR:   b_pos = cur_r;
      B_PREV:  b_pos = prev_r;
      B_PPREV: b_pos = pprev_r;
      default: b_pos = cur_r;
    endcase
  end

  assign job.start  = job_start;
  assign job.scale2 = scale2_r;

  ssr_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (job),
    .a_pos           (cur_r),
    .b_pos           (b_pos),
    .frame_rate      (frame_rate_r),
    .speed_threshold (threshold_r),
    .res             (res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE:   if (in_accept) state_nxt = T_PLAN;
      T_PLAN:   state_nxt = no_result ? T_FINISH : T_RUN;
      T_RUN:    if (res.done) state_nxt = T_HOLD;
      T_HOLD: begin
        if (out_free) state_nxt = second_r ? T_RUN : T_FINISH;
      end
      T_FINISH: state_nxt = T_IDLE;
      default:  state_nxt = T_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ready_c     = 1'b0;
    job_start   = 1'b0;
    out_load    = 1'b0;
    plan_first  = 1'b0;
    plan_second = 1'b0;
    case (state_r)
      T_IDLE: ready_c = 1'b1;
      T_PLAN: begin
        if (!no_result) begin
          job_start  = 1'b1;
          plan_first = 1'b1;
        end
      end
      T_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (second_r) begin
            job_start   = 1'b1;
            plan_second = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = ready_c;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_sat_r, out_ratio_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      frame_rate_r <= FRAME_RATE_RST;
      threshold_r  <= THRESHOLD_RST;
      frames_r     <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FRAME_RATE:      frame_rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_SPEED_THRESHOLD: threshold_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == T_FINISH) begin
        if (last_r) begin
          frames_r <= 2'd0;
        end else if (frames_r != 2'd2) begin
          frames_r <= frames_r + 2'd1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_r[0] <= in_tdata[POS_W-1:0];
      cur_r[1] <= in_tdata[2*POS_W-1:POS_W];
      cur_r[2] <= in_tdata[3*POS_W-1:2*POS_W];
      last_r   <= in_tlast;
    end
    if (state_r == T_FINISH && !last_r) begin
      pprev_r <= prev_r;
      prev_r  <= cur_r;
    end
    // A lone frame subtracts itself, which gives a speed of zero.
    if (plan_first) begin
      case (frames_r)
        2'd0: begin
          bsel_r    <= B_CUR;
          scale2_r  <= 1'b1;
          run_end_r <= 1'b1;
          second_r  <= 1'b0;
        end
        2'd1: begin
          bsel_r    <= B_PREV;
          scale2_r  <= 1'b1;
          run_end_r <= 1'b0;
          second_r  <= last_r;
        end
        default: begin
          bsel_r    <= B_PPREV;
          scale2_r  <= 1'b0;
          run_end_r <= 1'b0;
          second_r  <= last_r;
        end
      endcase
    end else if (plan_second) begin
      bsel_r    <= B_PREV;
      scale2_r  <= 1'b1;
      run_end_r <= 1'b1;
      second_r  <= 1'b0;
    end
    if (out_load) begin
      out_ratio_r <= res.ratio;
      out_sat_r   <= res.sat;
      out_last_r  <= run_end_r;
    end
  end

endmodule

### hdl/ssr_engine.sv
// Iterative engine: scaled differences, sum of squares, square root and divide.
module ssr_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssr_pkg::ssr_job_t           job,
  input  ssr_pkg::pos_vec_t           a_pos,
  input  ssr_pkg::pos_vec_t           b_pos,
  input  logic [ssr_pkg::RATE_W-1:0]  frame_rate,
  input  logic [ssr_pkg::THR_W-1:0]   speed_threshold,
  output ssr_pkg::ssr_res_t           res
);
  import ssr_pkg::*;

  eng_state_t           state_r, state_nxt;
  logic [1:0]           axis_r, axis_nxt;
  sq_phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [POS_W-1:0]     diff_r, diff_nxt;
  logic [W_W-1:0]       w_r, w_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ROOT_W-1:0]    root_r, root_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [RATIO_W-1:0]   quo_r, quo_nxt;
  logic                 sat_r, sat_nxt;

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     sq_term;
  logic [CS_W-1:0]      cs_lhs, cs_rhs;
  logic [CS_W:0]        cs_diff;
  logic                 cs_ge;
  logic [POS_W:0]       sdiff;
  logic [POS_W:0]       sdiff_abs;
  logic [DEN_W-1:0]     den;
  logic [LIM_W-1:0]     limit;
  logic                 over;
  logic                 last_axis;
  logic                 cnt_zero;

  assign den       = {speed_threshold, 1'b0};
  assign limit     = LIM_W'(den) << (RATIO_W - FRAC_BITS);
  assign over      = (LIM_W'(root_r) >= limit) || (speed_threshold == '0);
  assign last_axis = (axis_r == 2'd2);
  assign cnt_zero  = (cnt_r == '0);

  // Signed difference of one axis and its magnitude.
  assign sdiff     = {a_pos[axis_r][POS_W-1], a_pos[axis_r]}
                   - {b_pos[axis_r][POS_W-1], b_pos[axis_r]};
  assign sdiff_abs = sdiff[POS_W] ? -sdiff : sdiff;

  // The one multiplier and the one compare-subtract unit.
  assign prod    = mul_a * mul_b;
  assign cs_diff = {1'b0, cs_lhs} - {1'b0, cs_rhs};
  assign cs_ge   = ~cs_diff[CS_W];

  always_comb begin
    mul_a   = diff_r;
    mul_b   = MUL_B_W'(frame_rate);
    sq_term = '0;
    case (phase_r)
      PH_LL: begin
        mul_a = MUL_A_W'(w_r[WL_W-1:0]);
        mul_b = w_r[WL_W-1:0];
      end
      PH_HL: begin
        mul_a = MUL_A_W'(w_r[W_W-1:WL_W]);
        mul_b = w_r[WL_W-1:0];
      end
      PH_HH: begin
        mul_a = MUL_A_W'(w_r[W_W-1:WL_W]);
        mul_b = MUL_B_W'(w_r[W_W-1:WL_W]);
      end
      default: ;
    endcase
    if (state_r == E_MULW) begin
      mul_a = diff_r;
      mul_b = MUL_B_W'(frame_rate);
    end
    case (phase_r)
      PH_LL:   sq_term = ACC_W'(prod);
      PH_HL:   sq_term = ACC_W'(prod) << (WL_W + 1);
      PH_HH:   sq_term = ACC_W'(prod) << (2 * WL_W);
      default: sq_term = '0;
    endcase
  end

  always_comb begin
    if (state_r == E_DIV) begin
      cs_lhs = {1'b0, rem_r, quo_r[RATIO_W-1]};
      cs_rhs = CS_W'(den);
    end else begin
      cs_lhs = {rem_r, acc_r[ACC_W-1 -: 2]};
      cs_rhs = {2'b00, root_r, 2'b01};
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE:  if (job.start) state_nxt = E_ABS;
      E_ABS:   state_nxt = E_MULW;
      E_MULW:  state_nxt = E_SQ;
      E_SQ: begin
        if (phase_r == PH_HH) state_nxt = last_axis ? E_SQRT : E_ABS;
      end
      E_SQRT:  if (cnt_zero) state_nxt = E_CHECK;
      E_CHECK: state_nxt = over ? E_DONE : E_DIV;
      E_DIV:   if (cnt_zero) state_nxt = E_DONE;
      E_DONE:  state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  // Datapath updates per state. The result registers keep their value while
  // idle, so a finished word stays valid until the next job overwrites it.
  always_comb begin
    axis_nxt  = axis_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    diff_nxt  = diff_r;
    w_nxt     = w_r;
    acc_nxt   = acc_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    sat_nxt   = sat_r;
    case (state_r)
      E_IDLE: begin
        axis_nxt = '0;
        acc_nxt  = '0;
      end
      E_ABS: diff_nxt = sdiff_abs[POS_W-1:0];
      E_MULW: begin
        w_nxt     = job.scale2 ? {prod[W_W-2:0], 1'b0} : {1'b0, prod[W_W-2:0]};
        phase_nxt = PH_LL;
      end
      E_SQ: begin
        acc_nxt = acc_r + sq_term;
        case (phase_r)
          PH_LL:   phase_nxt = PH_HL;
          PH_HL:   phase_nxt = PH_HH;
          default: begin
            phase_nxt = PH_LL;
            axis_nxt  = axis_r + 2'd1;
            root_nxt  = '0;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(SQRT_STEPS - 1);
          end
        endcase
      end
      E_SQRT: begin
        acc_nxt = {acc_r[ACC_W-3:0], 2'b00};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cs_ge) begin
          rem_nxt  = cs_diff[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = cs_lhs[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      E_CHECK: begin
        sat_nxt = over;
        rem_nxt = REM_W'(root_r >> (RATIO_W - FRAC_BITS));
        quo_nxt = {root_r[RATIO_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        cnt_nxt = CNT_W'(DIV_STEPS - 1);
      end
      E_DIV: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cs_ge) begin
          rem_nxt = cs_diff[REM_W-1:0];
          quo_nxt = {quo_r[RATIO_W-2:0], 1'b1};
        end else begin
          rem_nxt = cs_lhs[REM_W-1:0];
          quo_nxt = {quo_r[RATIO_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // Result outputs.
  always_comb begin
    res.done  = (state_r == E_DONE);
    res.sat   = sat_r;
    res.ratio = sat_r ? '1 : quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r  <= axis_nxt;
    phase_r <= phase_nxt;
    cnt_r   <= cnt_nxt;
    diff_r  <= diff_nxt;
    w_r     <= w_nxt;
    acc_r   <= acc_nxt;
    root_r  <= root_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    sat_r   <= sat_nxt;
  end

endmodule
